[sv/u8sd_pkg.sv]
package u8sd_pkg;

  // result kinds on the output beat
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // error codes on the output beat
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_STRAY    = 3'd2,
    ERR_LATE_BOM = 3'd3,
    ERR_EMPTY    = 3'd4
  } err_t;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] BOM_CODE = 21'h00FEFF;

  // one decoded result
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    kind_t           kind;
    err_t            err;
  } result_t;

  // decoder state carried between bytes
  typedef struct packed {
    logic [1:0]      pending_count;
    logic [CP_W-1:0] accumulator;
    logic            emitted_any;
    logic            failed;
    err_t            held_error;
  } dec_state_t;

endpackage

[sv/utf8_stream_decoder.sv]
// an accepted byte's result is registered in the output register, or in the skid stage while the output is held
// throughput: one byte per clock, limited only by downstream stall
// an output register plus one skid stage keep input accept off out_stall
// reset (rst, synchronous): decoder state, output and skid valids cleared
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] code_point,
  output logic [1:0]  result_kind,
  output logic [2:0]  error_code
);

  logic               accept;
  logic               res_valid;
  u8sd_pkg::result_t  res;
  u8sd_pkg::result_t  out_res;
  u8sd_pkg::result_t  skid_res;
  logic               skid_valid;

  // input beat taken whenever the skid stage is free
  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;

  u8sd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .res_valid     (res_valid),
    .res           (res)
  );

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (res_valid) begin
        skid_valid <= 1'b1;
      end
    end else begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (res_valid) begin
        skid_res <= res;
      end
    end else begin
      out_res <= skid_valid ? skid_res : res;
    end
  end

  assign code_point  = out_res.code_point;
  assign result_kind = out_res.kind;
  assign error_code  = out_res.err;

`ifndef NO_ASSERTIONS
  // skid stage only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid valid without output valid");

  // character beats carry no error code
  a_char_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == u8sd_pkg::KIND_CHAR |-> error_code == u8sd_pkg::ERR_NONE)
    else $error("character with error code");

  // non-character beats carry a zero code point
  a_ctrl_zero_cp: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != u8sd_pkg::KIND_CHAR |-> code_point == '0)
    else $error("code point on control beat");
`endif

endmodule

[sv/u8sd_core.sv]
module u8sd_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               end_of_stream,
  output logic               res_valid,
  output u8sd_pkg::result_t  res
);

  u8sd_pkg::dec_state_t state;
  u8sd_pkg::dec_state_t state_next;

  logic [u8sd_pkg::CP_W-1:0] acc_shifted;
  logic [1:0]                pend_dec;

  // continuation byte shifts six payload bits in
  assign acc_shifted = {state.accumulator[u8sd_pkg::CP_W-7:0], data_byte[5:0]};
  assign pend_dec    = state.pending_count - 2'd1;

  // decode one beat
  always_comb begin
    state_next     = state;
    res_valid      = 1'b0;
    res.code_point = '0;
    res.kind       = u8sd_pkg::KIND_CHAR;
    res.err        = u8sd_pkg::ERR_NONE;
    if (accept) begin
      if (end_of_stream) begin
        // end marker reports and clears everything
        res_valid = 1'b1;
        if (state.failed) begin
          res.kind = u8sd_pkg::KIND_ERROR;
          res.err  = state.held_error;
        end else if (state.pending_count != 2'd0) begin
          res.kind = u8sd_pkg::KIND_ERROR;
          res.err  = u8sd_pkg::ERR_SHORT;
        end else if (!state.emitted_any) begin
          res.kind = u8sd_pkg::KIND_ERROR;
          res.err  = u8sd_pkg::ERR_EMPTY;
        end else begin
          res.kind = u8sd_pkg::KIND_END;
        end
        state_next = '0;
      end else if (!state.failed) begin
        if (!data_byte[7]) begin
          // ascii
          if (state.pending_count != 2'd0) begin
            res_valid             = 1'b1;
            res.kind              = u8sd_pkg::KIND_ERROR;
            res.err               = u8sd_pkg::ERR_SHORT;
            state_next.failed     = 1'b1;
            state_next.held_error = u8sd_pkg::ERR_SHORT;
          end else if (data_byte != 8'h00) begin
            res_valid              = 1'b1;
            res.code_point         = {13'd0, data_byte};
            state_next.emitted_any = 1'b1;
          end
        end else if (data_byte[7:6] == 2'b10) begin
          // continuation
          if (state.pending_count == 2'd0) begin
            res_valid             = 1'b1;
            res.kind              = u8sd_pkg::KIND_ERROR;
            res.err               = u8sd_pkg::ERR_STRAY;
            state_next.failed     = 1'b1;
            state_next.held_error = u8sd_pkg::ERR_STRAY;
          end else begin
            state_next.pending_count = pend_dec;
            state_next.accumulator   = acc_shifted;
            if (pend_dec == 2'd0) begin
              if (acc_shifted == u8sd_pkg::BOM_CODE) begin
                // leading bom dropped, later bom is an error
                if (state.emitted_any) begin
                  res_valid             = 1'b1;
                  res.kind              = u8sd_pkg::KIND_ERROR;
                  res.err               = u8sd_pkg::ERR_LATE_BOM;
                  state_next.failed     = 1'b1;
                  state_next.held_error = u8sd_pkg::ERR_LATE_BOM;
                end
              end else begin
                res_valid              = 1'b1;
                res.code_point         = acc_shifted;
                state_next.emitted_any = 1'b1;
              end
            end
          end
        end else if (data_byte[7:5] == 3'b110) begin
          state_next.pending_count = 2'd1;
          state_next.accumulator   = {16'd0, data_byte[4:0]};
        end else if (data_byte[7:4] == 4'b1110) begin
          state_next.pending_count = 2'd2;
          state_next.accumulator   = {17'd0, data_byte[3:0]};
        end else if (data_byte[7:3] == 5'b11110) begin
          state_next.pending_count = 2'd3;
          state_next.accumulator   = {18'd0, data_byte[2:0]};
        end
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  // end marker leaves the decoder in its reset state
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_stream |=> state == '0)
    else $error("state not cleared after end marker");

  // a failed stream stays silent until the end marker
  a_failed_silent: assert property (@(posedge clk) disable iff (rst)
    state.failed && accept && !end_of_stream |-> !res_valid)
    else $error("result after sticky error");

  // an error result always sets the sticky flag unless it ends the stream
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == u8sd_pkg::KIND_ERROR && !end_of_stream |=> state.failed)
    else $error("error not held");
`endif

endmodule

[test/tb_utf8_stream_decoder.sv]
module tb_utf8_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1600;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCH_LIMIT = 2000;
  localparam int DIR_ROWS    = 30;

  localparam u8sd_pkg::result_t NO_RES = '{21'h0, u8sd_pkg::KIND_CHAR, u8sd_pkg::ERR_NONE};

  // one row of the directed table; typed rows carry their own expected beat
  typedef struct {
    logic [7:0]        b;
    logic              eos;
    bit                typed;
    u8sd_pkg::result_t res;
  } dir_row_t;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, '{21'h0, u8sd_pkg::KIND_ERROR, u8sd_pkg::ERR_EMPTY}},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h7F, 1'b0, 1'b1, '{21'h7F, u8sd_pkg::KIND_CHAR, u8sd_pkg::ERR_NONE}},
    '{8'hC2, 1'b0, 1'b0, NO_RES},
    '{8'hA9, 1'b0, 1'b0, NO_RES},
    '{8'hEF, 1'b0, 1'b0, NO_RES},
    '{8'hBB, 1'b0, 1'b0, NO_RES},
    '{8'hBF, 1'b0, 1'b1, '{21'h0, u8sd_pkg::KIND_ERROR, u8sd_pkg::ERR_LATE_BOM}},
    '{8'h41, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b1, '{21'h0, u8sd_pkg::KIND_ERROR, u8sd_pkg::ERR_LATE_BOM}},
    '{8'hEF, 1'b0, 1'b0, NO_RES},
    '{8'hBB, 1'b0, 1'b0, NO_RES},
    '{8'hBF, 1'b0, 1'b0, NO_RES},
    '{8'hF7, 1'b0, 1'b0, NO_RES},
    '{8'hBF, 1'b0, 1'b0, NO_RES},
    '{8'hBF, 1'b0, 1'b0, NO_RES},
    '{8'hBF, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'hE0, 1'b0, 1'b0, NO_RES},
    '{8'hC3, 1'b0, 1'b0, NO_RES},
    '{8'hA9, 1'b0, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b1, '{21'h0, u8sd_pkg::KIND_ERROR, u8sd_pkg::ERR_STRAY}},
    '{8'h00, 1'b1, 1'b1, '{21'h0, u8sd_pkg::KIND_ERROR, u8sd_pkg::ERR_STRAY}},
    '{8'hE2, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, '{21'h0, u8sd_pkg::KIND_ERROR, u8sd_pkg::ERR_SHORT}},
    '{8'h00, 1'b1, 1'b1, '{21'h0, u8sd_pkg::KIND_ERROR, u8sd_pkg::ERR_SHORT}},
    '{8'hC5, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b1, '{21'h0, u8sd_pkg::KIND_ERROR, u8sd_pkg::ERR_SHORT}},
    '{8'h41, 1'b0, 1'b1, '{21'h41, u8sd_pkg::KIND_CHAR, u8sd_pkg::ERR_NONE}},
    '{8'h00, 1'b1, 1'b1, '{21'h0, u8sd_pkg::KIND_END, u8sd_pkg::ERR_NONE}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [20:0] code_point;
  logic [1:0]  result_kind;
  logic [2:0]  error_code;

  // side info travelling with the offered input beat
  bit                cur_typed = 1'b0;
  u8sd_pkg::result_t cur_res = NO_RES;

  u8sd_pkg::result_t predicted_out [$];
  u8sd_pkg::result_t mon_res;
  u8sd_pkg::result_t got_res;
  int          fails = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  int          tx_mode = 1;
  int          rx_mode = 1;

  // decoder state mirror
  logic [1:0]     pend_left = '0;
  logic [20:0]    cp_acc = '0;
  bit             any_out = 1'b0;
  bit             stream_failed = 1'b0;
  u8sd_pkg::err_t failed_code = u8sd_pkg::ERR_NONE;

  utf8_stream_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_point    (code_point),
    .result_kind   (result_kind),
    .error_code    (error_code)
  );

  always #5 clk = ~clk;

  // error becomes sticky until the end beat
  function automatic bit flag_error(input u8sd_pkg::err_t code,
                                    output u8sd_pkg::result_t res);
    stream_failed = 1'b1;
    failed_code   = code;
    res           = '{21'h0, u8sd_pkg::KIND_ERROR, code};
    return 1'b1;
  endfunction

  // advance the decoder mirror by one input beat; returns 1 when a result is due
  function automatic bit decode_beat(input logic [7:0] b, input logic eos,
                                     output u8sd_pkg::result_t res);
    res = NO_RES;
    if (eos) begin
      res.kind = u8sd_pkg::KIND_ERROR;
      if (stream_failed) res.err = failed_code;
      else if (pend_left != 2'd0) res.err = u8sd_pkg::ERR_SHORT;
      else if (!any_out) res.err = u8sd_pkg::ERR_EMPTY;
      else res.kind = u8sd_pkg::KIND_END;
      pend_left     = '0;
      cp_acc        = '0;
      any_out       = 1'b0;
      stream_failed = 1'b0;
      failed_code   = u8sd_pkg::ERR_NONE;
      return 1'b1;
    end
    if (stream_failed) return 1'b0;
    if (b < 8'h80) begin
      if (pend_left != 2'd0) return flag_error(u8sd_pkg::ERR_SHORT, res);
      if (b == 8'h00) return 1'b0;
      any_out = 1'b1;
      res.code_point = {14'h0, b[6:0]};
      return 1'b1;
    end
    if (b < 8'hC0) begin
      if (pend_left == 2'd0) return flag_error(u8sd_pkg::ERR_STRAY, res);
      pend_left = pend_left - 2'd1;
      cp_acc    = {cp_acc[14:0], b[5:0]};
      if (pend_left != 2'd0) return 1'b0;
      if (cp_acc == u8sd_pkg::BOM_CODE) begin
        if (any_out) return flag_error(u8sd_pkg::ERR_LATE_BOM, res);
        return 1'b0;
      end
      any_out = 1'b1;
      res.code_point = cp_acc;
      return 1'b1;
    end
    if (b < 8'hE0) begin
      pend_left = 2'd1;
      cp_acc    = {16'h0, b[4:0]};
    end else if (b < 8'hF0) begin
      pend_left = 2'd2;
      cp_acc    = {17'h0, b[3:0]};
    end else if (b < 8'hF8) begin
      pend_left = 2'd3;
      cp_acc    = {18'h0, b[2:0]};
    end
    return 1'b0;
  endfunction

  // idle cycles before a beat: none, occasional, or always random
  function automatic int draw_wait(input int mode);
    case (mode)
      0:       return 0;
      1:       return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 18) : 0;
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  // offer one input beat and hold it until accepted
  task automatic send_beat(input logic [7:0] b, input logic eos, input bit typed,
                           input u8sd_pkg::result_t res);
    int gap;
    gap = draw_wait(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    cur_typed     <= typed;
    cur_res       <= res;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // encode a code point in nb bytes and send the first count of them
  task automatic send_code(input int nb, input logic [20:0] cp, input int count);
    logic [7:0] seq [4];
    case (nb)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int k = 0; k < count; k++) send_beat(seq[k], 1'b0, 1'b0, NO_RES);
  endtask

  // one stream: mostly well-formed characters, some noise, then the end beat
  task automatic send_stream();
    int          n_chars;
    int          pick;
    int          nb;
    int          cut;
    logic [20:0] cp;
    logic [7:0]  noise;
    n_chars = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
    repeat (n_chars) begin
      pick = $urandom_range(0, 99);
      cut  = 0;
      nb   = 0;
      if (pick < 35) begin
        nb = 1;
        cp = 21'($urandom_range(1, 127));
      end else if (pick < 55) begin
        nb = 2;
        cp = 21'($urandom_range(0, 'h7FF));
      end else if (pick < 75) begin
        nb = 3;
        cp = 21'($urandom_range(0, 'hFFFF));
      end else if (pick < 85) begin
        nb = 4;
        cp = 21'($urandom_range(0, 'h1FFFFF));
      end else if (pick < 89) begin
        nb = 3;
        cp = u8sd_pkg::BOM_CODE;
      end else if (pick < 94) begin
        // truncated sequence, cut off by whatever follows
        nb  = $urandom_range(2, 4);
        cp  = 21'($urandom);
        cut = $urandom_range(1, nb - 1);
      end else begin
        case ($urandom_range(0, 3))
          0:       noise = 8'h00;
          1:       noise = 8'($urandom_range('h80, 'hBF));
          2:       noise = 8'($urandom_range('hF8, 'hFF));
          default: noise = 8'($urandom_range(0, 255));
        endcase
        send_beat(noise, 1'b0, 1'b0, NO_RES);
      end
      if (nb > 0) send_code(nb, cp, nb - cut);
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_RES);
  endtask

  // stop offering and wait until every predicted beat has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_out.size() != 0) @(posedge clk);
  endtask

  // predict on every accepted input beat
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      if (decode_beat(data_byte, end_of_stream, mon_res)) begin
        if (cur_typed) predicted_out.push_back(cur_res);
        else predicted_out.push_back(mon_res);
      end
    end
  end

  // compare every accepted output beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (predicted_out.size() == 0) begin
        $error("result beat with nothing predicted: cp %h kind %0d err %0d",
               code_point, result_kind, error_code);
        fails++;
      end else begin
        got_res = predicted_out.pop_front();
        if (code_point !== got_res.code_point) begin
          $error("code_point: expected %h, got %h", got_res.code_point, code_point);
          fails++;
        end
        if (result_kind !== got_res.kind) begin
          $error("result_kind: expected %0d, got %0d", got_res.kind, result_kind);
          fails++;
        end
        if (error_code !== got_res.err) begin
          $error("error_code: expected %0d, got %0d", got_res.err, error_code);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("utf8_stream_decoder: mismatch");
      $finish;
    end
  end

  // receiver: random stall per beat, two long hold-offs to fill the block
  initial begin
    int n;
    int taken;
    taken = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % 40 == 0) rx_mode = $urandom_range(0, 2);
      if (taken == 150 || taken == 500) n = HOLD_CYCLES;
      else n = draw_wait(rx_mode);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // sender: directed table, then random streams
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DIR_ROWS; i++)
      send_beat(dir_tab[i].b, dir_tab[i].eos, dir_tab[i].typed, dir_tab[i].res);
    drain_results();
    while (items_sent < DIR_ROWS + ITEM_TARGET) begin
      tx_mode = $urandom_range(0, 2);
      send_stream();
      if ($urandom_range(0, 7) == 0) drain_results();
    end
    drain_results();
    repeat (8) @(posedge clk);
    if (fails == 0) $display("utf8_stream_decoder: match");
    else $display("utf8_stream_decoder: mismatch");
    $finish;
  end

endmodule

[files.f]
sv/u8sd_pkg.sv
sv/u8sd_core.sv
sv/utf8_stream_decoder.sv
test/tb_utf8_stream_decoder.sv
